### rtl/core/cfpp_pkg.sv
// Shared types, constants and codes for the CRC16 framed packet parser.
package cfpp_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 8'd1;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_ACCEPT  = 2'd2,
    EV_CRC_ERR = 2'd3
  } event_t;

  typedef enum logic [3:0] {
    PH_SYNC1 = 4'd0,
    PH_SYNC2 = 4'd1,
    PH_CMD   = 4'd2,
    PH_SEQH  = 4'd3,
    PH_SEQL  = 4'd4,
    PH_LENH  = 4'd5,
    PH_LENL  = 4'd6,
    PH_DATA  = 4'd7,
    PH_CRCH  = 4'd8,
    PH_CRCL  = 4'd9
  } phase_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data_byte;
    logic [9:0]  data_index;
    logic [7:0]  frame_cmd;
    logic [15:0] frame_seq;
    logic [10:0] frame_len;
  } result_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } cfg_t;

endpackage

### rtl/core/cfpp_crc_unit.sv
// Byte-wide CRC16-Modbus update, unrolled over eight bit steps.
module cfpp_crc_unit (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'd0, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ cfpp_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

### rtl/core/cfpp_parser.sv
// Frame parsing state machine, header holds, CRC accumulator and result logic.
module cfpp_parser #(
  parameter int unsigned MAX_PAYLOAD = cfpp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  cfpp_pkg::cfg_t    cfg,
  output cfpp_pkg::result_t result
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  cfpp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  cmd_hold_r, cmd_hold_nxt;
  logic [15:0] seq_hold_r, seq_hold_nxt;
  logic [15:0] len_hold_r, len_hold_nxt;
  logic [10:0] idx_count_r, idx_count_nxt;
  logic [15:0] crc_acc_r, crc_acc_nxt;
  logic [7:0]  crc_high_r, crc_high_nxt;

  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [10:0] idx_inc;

  cfpp_crc_unit u_crc (
    .crc_in  (crc_acc_r),
    .data_in (rx_byte),
    .crc_out (crc_upd)
  );

  assign len_full = {len_hold_r[15:8], rx_byte};
  assign idx_inc  = idx_count_r + 11'd1;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      cfpp_pkg::PH_SYNC1: begin
        if (rx_byte == cfg.sync_first) phase_nxt = cfpp_pkg::PH_SYNC2;
      end
      cfpp_pkg::PH_SYNC2: begin
        phase_nxt = (rx_byte == cfg.sync_second) ? cfpp_pkg::PH_CMD : cfpp_pkg::PH_SYNC1;
      end
      cfpp_pkg::PH_CMD:  phase_nxt = cfpp_pkg::PH_SEQH;
      cfpp_pkg::PH_SEQH: phase_nxt = cfpp_pkg::PH_SEQL;
      cfpp_pkg::PH_SEQL: phase_nxt = cfpp_pkg::PH_LENH;
      cfpp_pkg::PH_LENH: phase_nxt = cfpp_pkg::PH_LENL;
      cfpp_pkg::PH_LENL: begin
        if (len_full > MAX_LEN) begin
          phase_nxt = cfpp_pkg::PH_SYNC1;
        end else if (len_full == 16'd0) begin
          phase_nxt = cfpp_pkg::PH_CRCH;
        end else begin
          phase_nxt = cfpp_pkg::PH_DATA;
        end
      end
      cfpp_pkg::PH_DATA: begin
        if ({5'd0, idx_inc} >= len_hold_r) phase_nxt = cfpp_pkg::PH_CRCH;
      end
      cfpp_pkg::PH_CRCH: phase_nxt = cfpp_pkg::PH_CRCL;
      cfpp_pkg::PH_CRCL: phase_nxt = cfpp_pkg::PH_SYNC1;
      default:           phase_nxt = cfpp_pkg::PH_SYNC1;
    endcase
  end

  always_comb begin
    cmd_hold_nxt  = cmd_hold_r;
    seq_hold_nxt  = seq_hold_r;
    len_hold_nxt  = len_hold_r;
    idx_count_nxt = idx_count_r;
    crc_acc_nxt   = crc_acc_r;
    crc_high_nxt  = crc_high_r;
    result        = '0;
    unique case (phase_r)
      cfpp_pkg::PH_SYNC1: ;
      cfpp_pkg::PH_SYNC2: begin
        if (rx_byte == cfg.sync_second) crc_acc_nxt = cfpp_pkg::CRC_SEED;
      end
      cfpp_pkg::PH_CMD: begin
        cmd_hold_nxt = rx_byte;
        crc_acc_nxt  = crc_upd;
      end
      cfpp_pkg::PH_SEQH: begin
        seq_hold_nxt = {rx_byte, 8'd0};
        crc_acc_nxt  = crc_upd;
      end
      cfpp_pkg::PH_SEQL: begin
        seq_hold_nxt = {seq_hold_r[15:8], rx_byte};
        crc_acc_nxt  = crc_upd;
      end
      cfpp_pkg::PH_LENH: begin
        len_hold_nxt = {rx_byte, 8'd0};
        crc_acc_nxt  = crc_upd;
      end
      cfpp_pkg::PH_LENL: begin
        len_hold_nxt  = len_full;
        crc_acc_nxt   = crc_upd;
        idx_count_nxt = '0;
      end
      cfpp_pkg::PH_DATA: begin
        result.event_res  = cfpp_pkg::EV_PAYLOAD;
        result.data_byte  = rx_byte;
        result.data_index = idx_count_r[9:0];
        crc_acc_nxt       = crc_upd;
        idx_count_nxt     = idx_inc;
      end
      cfpp_pkg::PH_CRCH: crc_high_nxt = rx_byte;
      cfpp_pkg::PH_CRCL: begin
        if ({crc_high_r, rx_byte} == crc_acc_r) begin
          result.event_res = cfpp_pkg::EV_ACCEPT;
          result.frame_cmd = cmd_hold_r;
          result.frame_seq = seq_hold_r;
          result.frame_len = len_hold_r[10:0];
        end else begin
          result.event_res = cfpp_pkg::EV_CRC_ERR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cfpp_pkg::PH_SYNC1;
      cmd_hold_r  <= '0;
      seq_hold_r  <= '0;
      len_hold_r  <= '0;
      idx_count_r <= '0;
      crc_acc_r   <= cfpp_pkg::CRC_SEED;
      crc_high_r  <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      cmd_hold_r  <= cmd_hold_nxt;
      seq_hold_r  <= seq_hold_nxt;
      len_hold_r  <= len_hold_nxt;
      idx_count_r <= idx_count_nxt;
      crc_acc_r   <= crc_acc_nxt;
      crc_high_r  <= crc_high_nxt;
    end
  end

endmodule

### rtl/core/crc16_framed_packet_parser_top.sv
// Top level of the CRC16 framed packet parser.
//
// Input channel in_*: one received byte per transfer. Every accepted byte
// produces exactly one result transfer on out_*: event 0 (nothing), 1 (payload
// byte with its index), 2 (frame accepted with command, sequence, length) or
// 3 (CRC mismatch). Fields not meaningful for an event are zero.
// The result appears in the output register in the cycle after the byte is
// taken. Throughput is one byte per cycle unless the receiver stalls out_ready,
// set by the combinational byte-wide CRC update and parser state step.
// A new byte is taken while the output register is empty or being emptied in
// the same cycle; when the receiver holds out_ready low with a result pending,
// in_ready drops and parser state holds.
// cfg_*: register writes (index 0 first sync byte, 1 second sync byte), always
// ready; other indexes are ignored. Write only while the block is idle.
// Reset (rst_n low, synchronous) returns the parser to sync search, sets the
// sync bytes to 0x55 and 0xAA, and empties the output register.
module crc16_framed_packet_parser_top #(
  parameter int unsigned MAX_PAYLOAD = cfpp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_event_res,
  output logic [7:0]                     out_data_byte,
  output logic [9:0]                     out_data_index,
  output logic [7:0]                     out_frame_cmd,
  output logic [15:0]                    out_frame_seq,
  output logic [10:0]                    out_frame_len,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cfpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  cfpp_pkg::cfg_t    cfg_r;
  cfpp_pkg::result_t result;
  cfpp_pkg::result_t out_r;
  logic              out_valid_r;
  logic              step;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign step      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first  <= cfpp_pkg::SYNC_FIRST_RST;
      cfg_r.sync_second <= cfpp_pkg::SYNC_SECOND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cfpp_pkg::CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_data;
        cfpp_pkg::CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  cfpp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_res  = out_r.event_res;
  assign out_data_byte  = out_r.data_byte;
  assign out_data_index = out_r.data_index;
  assign out_frame_cmd  = out_r.frame_cmd;
  assign out_frame_seq  = out_r.frame_seq;
  assign out_frame_len  = out_r.frame_len;

endmodule

### bench/crc16_framed_packet_parser_checker.sv
// Scoreboard for the CRC16 framed packet parser: parses accepted bytes and checks each result.
`timescale 1ns / 1ps

package cfpp_tb_pkg;

  localparam logic [15:0] MODBUS_INIT = 16'hFFFF;
  localparam logic [15:0] MODBUS_POLY = 16'hA001;

  function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ MODBUS_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module crc16_framed_packet_parser_checker #(
  parameter int unsigned MAX_PAYLOAD = cfpp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     out_event_res,
  input  logic [7:0]                     out_data_byte,
  input  logic [9:0]                     out_data_index,
  input  logic [7:0]                     out_frame_cmd,
  input  logic [15:0]                    out_frame_seq,
  input  logic [10:0]                    out_frame_len,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [cfpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int                             mismatches,
  output int                             pending,
  output int                             frames_ok,
  output int                             frames_bad,
  output int                             payload_seen
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  logic [7:0]        sync1_val;
  logic [7:0]        sync2_val;
  cfpp_pkg::phase_t  ph;
  logic [7:0]        cmd_q;
  logic [15:0]       seq_q;
  logic [15:0]       len_q;
  logic [10:0]       idx_q;
  logic [15:0]       crc_q;
  logic [7:0]        crc_hi_q;
  cfpp_pkg::result_t parse_results_due[$];

  function automatic cfpp_pkg::result_t parse_byte(input logic [7:0] b);
    cfpp_pkg::result_t r;
    r = '0;
    case (ph)
      cfpp_pkg::PH_SYNC1: begin
        if (b == sync1_val) ph = cfpp_pkg::PH_SYNC2;
      end
      cfpp_pkg::PH_SYNC2: begin
        if (b == sync2_val) begin
          ph = cfpp_pkg::PH_CMD;
          crc_q = cfpp_tb_pkg::MODBUS_INIT;
        end else begin
          ph = cfpp_pkg::PH_SYNC1;
        end
      end
      cfpp_pkg::PH_CMD: begin
        cmd_q = b;
        crc_q = cfpp_tb_pkg::crc16_modbus_byte(crc_q, b);
        ph = cfpp_pkg::PH_SEQH;
      end
      cfpp_pkg::PH_SEQH: begin
        seq_q = {b, 8'h00};
        crc_q = cfpp_tb_pkg::crc16_modbus_byte(crc_q, b);
        ph = cfpp_pkg::PH_SEQL;
      end
      cfpp_pkg::PH_SEQL: begin
        seq_q = {seq_q[15:8], b};
        crc_q = cfpp_tb_pkg::crc16_modbus_byte(crc_q, b);
        ph = cfpp_pkg::PH_LENH;
      end
      cfpp_pkg::PH_LENH: begin
        len_q = {b, 8'h00};
        crc_q = cfpp_tb_pkg::crc16_modbus_byte(crc_q, b);
        ph = cfpp_pkg::PH_LENL;
      end
      cfpp_pkg::PH_LENL: begin
        len_q = {len_q[15:8], b};
        crc_q = cfpp_tb_pkg::crc16_modbus_byte(crc_q, b);
        idx_q = '0;
        if (len_q > MAX_LEN) ph = cfpp_pkg::PH_SYNC1;
        else if (len_q == 16'd0) ph = cfpp_pkg::PH_CRCH;
        else ph = cfpp_pkg::PH_DATA;
      end
      cfpp_pkg::PH_DATA: begin
        r.event_res = cfpp_pkg::EV_PAYLOAD;
        r.data_byte = b;
        r.data_index = idx_q[9:0];
        crc_q = cfpp_tb_pkg::crc16_modbus_byte(crc_q, b);
        idx_q = idx_q + 11'd1;
        if ({5'd0, idx_q} >= len_q) ph = cfpp_pkg::PH_CRCH;
      end
      cfpp_pkg::PH_CRCH: begin
        crc_hi_q = b;
        ph = cfpp_pkg::PH_CRCL;
      end
      cfpp_pkg::PH_CRCL: begin
        if ({crc_hi_q, b} == crc_q) begin
          r.event_res = cfpp_pkg::EV_ACCEPT;
          r.frame_cmd = cmd_q;
          r.frame_seq = seq_q;
          r.frame_len = len_q[10:0];
        end else begin
          r.event_res = cfpp_pkg::EV_CRC_ERR;
        end
        ph = cfpp_pkg::PH_SYNC1;
      end
      default: ph = cfpp_pkg::PH_SYNC1;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cfpp_pkg::result_t want;
    logic bad;
    if (!rst_n) begin
      sync1_val = cfpp_pkg::SYNC_FIRST_RST;
      sync2_val = cfpp_pkg::SYNC_SECOND_RST;
      ph = cfpp_pkg::PH_SYNC1;
      cmd_q = '0;
      seq_q = '0;
      len_q = '0;
      idx_q = '0;
      crc_q = cfpp_tb_pkg::MODBUS_INIT;
      crc_hi_q = '0;
      parse_results_due.delete();
      mismatches = 0;
      frames_ok = 0;
      frames_bad = 0;
      payload_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cfpp_pkg::CFG_SYNC_FIRST: sync1_val = cfg_data;
          cfpp_pkg::CFG_SYNC_SECOND: sync2_val = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) parse_results_due.push_back(parse_byte(in_rx_byte));
      if (out_valid && out_ready) begin
        if (parse_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with nothing outstanding: ev=%0d byte=%02h idx=%0d",
                     $time, out_event_res, out_data_byte, out_data_index);
        end else begin
          want = parse_results_due.pop_front();
          bad = (out_event_res !== want.event_res) || (out_data_byte !== want.data_byte) ||
                (out_data_index !== want.data_index) || (out_frame_cmd !== want.frame_cmd) ||
                (out_frame_seq !== want.frame_seq) || (out_frame_len !== want.frame_len);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected ev=%0d byte=%02h idx=%0d cmd=%02h seq=%04h len=%0d",
                       $time, want.event_res, want.data_byte, want.data_index,
                       want.frame_cmd, want.frame_seq, want.frame_len);
              $display("%0t:           got ev=%0d byte=%02h idx=%0d cmd=%02h seq=%04h len=%0d",
                       $time, out_event_res, out_data_byte, out_data_index,
                       out_frame_cmd, out_frame_seq, out_frame_len);
            end
          end else begin
            case (want.event_res)
              cfpp_pkg::EV_PAYLOAD: payload_seen++;
              cfpp_pkg::EV_ACCEPT: frames_ok++;
              cfpp_pkg::EV_CRC_ERR: frames_bad++;
              default: ;
            endcase
          end
        end
      end
    end
    pending = parse_results_due.size();
  end

endmodule

### bench/crc16_framed_packet_parser_top_tb.sv
// Testbench top for the CRC16 framed packet parser: frame stimulus, handshake mixes and verdict.
`timescale 1ns / 1ps

module crc16_framed_packet_parser_top_tb;

  typedef logic [cfpp_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_BYTES  = 150;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_event_res;
  logic [7:0]  out_data_byte;
  logic [9:0]  out_data_index;
  logic [7:0]  out_frame_cmd;
  logic [15:0] out_frame_seq;
  logic [10:0] out_frame_len;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  int mismatches;
  int pending;
  int frames_ok;
  int frames_bad;
  int payload_seen;

  int gap_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int cycles = 0;
  logic [7:0] cur_sync_first = cfpp_pkg::SYNC_FIRST_RST;
  logic [7:0] cur_sync_second = cfpp_pkg::SYNC_SECOND_RST;

  crc16_framed_packet_parser_top DUT (.*);

  crc16_framed_packet_parser_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles, %0d results outstanding", cycles, pending);
      $display("crc16_framed_packet_parser_top_tb: FAIL");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // crc_flip != 0 corrupts the trailing CRC; oversize lengths stop after the header
  task automatic push_frame(input logic [7:0] cmd, input logic [15:0] seq,
                            input logic [15:0] len, input logic [15:0] crc_flip);
    logic [15:0] crc;
    logic [7:0] hdr[5];
    logic [7:0] b;
    int i;
    hdr = '{cmd, seq[15:8], seq[7:0], len[15:8], len[7:0]};
    crc = cfpp_tb_pkg::MODBUS_INIT;
    push_byte(cur_sync_first);
    push_byte(cur_sync_second);
    for (i = 0; i < 5; i++) begin
      push_byte(hdr[i]);
      crc = cfpp_tb_pkg::crc16_modbus_byte(crc, hdr[i]);
    end
    if ({16'd0, len} <= cfpp_pkg::MAX_PAYLOAD_DEF) begin
      for (i = 0; i < int'(len); i++) begin
        b = 8'($urandom);
        push_byte(b);
        crc = cfpp_tb_pkg::crc16_modbus_byte(crc, b);
      end
      crc = crc ^ crc_flip;
      push_byte(crc[15:8]);
      push_byte(crc[7:0]);
    end
  endtask

  task automatic cfg_put(input cfg_idx_t idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_syncs(input logic [7:0] first, input logic [7:0] second);
    cfg_put(cfpp_pkg::CFG_SYNC_FIRST, first);
    cfg_put(cfpp_pkg::CFG_SYNC_SECOND, second);
    // unmapped index, must not disturb either sync byte
    cfg_put(cfg_idx_t'($urandom_range(2 ** cfpp_pkg::CFG_IDX_W - 1,
                                      cfpp_pkg::CFG_SYNC_SECOND + 1)),
            8'($urandom));
    cfg_valid <= 1'b0;
    cur_sync_first = first;
    cur_sync_second = second;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_traffic(input int n_bytes);
    int start;
    int pick;
    int len;
    logic [7:0] b;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      len = ($urandom_range(7) == 0) ? $urandom_range(64) : $urandom_range(12);
      if (pick < 70) begin
        push_frame(8'($urandom), 16'($urandom), 16'(len), 16'h0000);
      end else if (pick < 80) begin
        push_frame(8'($urandom), 16'($urandom), 16'(len), 16'h0001 << $urandom_range(15));
      end else if (pick < 85) begin
        push_frame(8'($urandom), 16'($urandom),
                   16'($urandom_range(65535, cfpp_pkg::MAX_PAYLOAD_DEF + 1)), 16'h0000);
      end else if (pick < 90) begin
        b = 8'($urandom);
        if (b == cur_sync_second) b = ~b;
        push_byte(cur_sync_first);
        push_byte(b);
      end else begin
        repeat ($urandom_range(6, 1)) push_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] same_sync;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset sync values; empty frame at field extremes
    push_frame(8'hFF, 16'hFFFF, 16'd0, 16'h0000);
    // second sync wrong (a repeated first sync byte); the following byte must not start a frame
    push_byte(cfpp_pkg::SYNC_FIRST_RST);
    push_byte(cfpp_pkg::SYNC_FIRST_RST);
    push_byte(cfpp_pkg::SYNC_SECOND_RST);
    // one past the maximum length
    push_frame(8'h00, 16'h0000, 16'(cfpp_pkg::MAX_PAYLOAD_DEF + 1), 16'h0000);
    // CRC mismatch on an empty frame
    push_frame(8'h5A, 16'h0100, 16'd0, 16'h8000);

    random_traffic(PHASE_BYTES);
    push_frame(8'($urandom), 16'($urandom), 16'(cfpp_pkg::MAX_PAYLOAD_DEF), 16'h0000);
    drain();

    gap_pct = 47;
    stall_pct = 0;
    write_syncs(8'h00, 8'hFF);
    random_traffic(PHASE_BYTES);
    drain();

    gap_pct = 0;
    stall_pct = 47;
    write_syncs(8'hFF, 8'h00);
    random_traffic(PHASE_BYTES);
    drain();

    gap_pct = 35;
    stall_pct = 35;
    same_sync = 8'($urandom);
    write_syncs(same_sync, same_sync);
    random_traffic(PHASE_BYTES);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d bytes sent: %0d frames accepted, %0d CRC drops, %0d payload bytes checked",
             bytes_sent, frames_ok, frames_bad, payload_seen);
    $display("sync pairs 55/AA, 00/FF, FF/00, %02h/%02h;", same_sync, same_sync);
    $display("free-flowing, sender gaps, receiver stalls, both");
    if (mismatches == 0 && pending == 0) begin
      $display("crc16_framed_packet_parser_top_tb: PASS");
    end else begin
      $display("crc16_framed_packet_parser_top_tb: FAIL");
    end
    $finish;
  end

endmodule
